// ===== hdl/bss_pkg.sv =====
// Shared types, codes and constants for the staircase bias sweeper.
package bss_pkg;

	localparam int LEVEL_W   = 15;
	localparam int COUNT_W   = 16;
	localparam int MASK_W    = 5;
	localparam int CODE_W    = 3;
	localparam int KIND_W    = 2;
	localparam int CHAN_W    = 3;

	localparam int BSS_QUEUE_DEPTH = 2;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd32767;
	localparam logic [LEVEL_W-1:0] LEVEL_MIN = 15'd1;

	// beat kinds on the input stream
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ARM    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MANUAL = 2'd2;

	localparam logic [CHAN_W-1:0] CHAN_LAST = 3'd4;
	localparam logic [CODE_W-1:0] ARRAY_ALL = 3'd3;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_SWEEP_START = 3'd0;
	localparam logic [2:0] REG_SWEEP_END   = 3'd1;
	localparam logic [2:0] REG_STEP_COUNT  = 3'd2;
	localparam logic [2:0] REG_DWELL_TICKS = 3'd3;
	localparam logic [2:0] REG_PULSE_TICKS = 3'd4;
	localparam logic [2:0] REG_ARRAY_CODE  = 3'd5;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_ARM,
		OP_MANUAL
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t             op;
		logic [MASK_W-1:0]   man_mask;
		logic [LEVEL_W-1:0]  level;
	} cmd_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] sweep_start;
		logic [LEVEL_W-1:0] sweep_end;
		logic [COUNT_W-1:0] step_count;
		logic [COUNT_W-1:0] dwell_ticks;
		logic [COUNT_W-1:0] pulse_ticks;
		logic [CODE_W-1:0]  array_code;
	} cfg_t;

	typedef struct packed {
		logic               write_valid;
		logic [MASK_W-1:0]  channel_mask;
		logic [LEVEL_W-1:0] bias_level;
		logic               sweep_active;
		logic               cal_request;
		logic [COUNT_W-1:0] cal_length;
	} result_t;

	typedef enum logic {
		BK_EXEC,
		BK_DIV
	} bk_state_t;

endpackage

// ===== hdl/bss_front.sv =====
// Front end: takes input beats and classifies them into queue commands.
module bss_front
	import bss_pkg::*;
(
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [23:0]         s_axis_tdata,   // [2:0] channel, [17:3] level, [23:18] zero
	input  logic [KIND_W-1:0]   s_axis_tuser,   // [1:0] kind
	input  logic                q_full,
	output logic                push,
	output cmd_t                push_cmd
);

	logic [CHAN_W-1:0]  chan;
	logic [LEVEL_W-1:0] lvl;

	assign chan = s_axis_tdata[CHAN_W-1:0];
	assign lvl  = s_axis_tdata[CHAN_W +: LEVEL_W];

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	always_comb begin
		push_cmd = '0;
		unique case (s_axis_tuser)
			KIND_ARM:    push_cmd.op = OP_ARM;
			KIND_MANUAL: push_cmd.op = OP_MANUAL;
			default:     push_cmd.op = OP_TICK;   // kind three runs as a tick
		endcase
		// manual writes beyond the last channel write nothing
		if (chan <= CHAN_LAST) begin
			push_cmd.man_mask = MASK_W'(1) << chan;
		end
		push_cmd.level = lvl;
	end

endmodule

// ===== hdl/bss_queue.sv =====
// Command queue between front and back end.
module bss_queue
	import bss_pkg::*;
#(
	parameter int DEPTH = BSS_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  cmd_t                       push_cmd,
	output logic                       full,
	input  logic                       pop,
	output logic                       head_valid,
	output cmd_t                       head_cmd,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign count      = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/bss_div.sv =====
// Restoring divider, one quotient bit per cycle, for the step size.
module bss_div
	import bss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [LEVEL_W-1:0] dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               done,
	output logic [LEVEL_W-1:0] quotient
);

	localparam int CNT_W = $clog2(LEVEL_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COUNT_W-1:0] rem_q;
	logic [LEVEL_W-1:0] quo_q;
	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   diff;
	logic               ge;

	assign trial = {rem_q, quo_q[LEVEL_W-1]};
	assign ge    = (trial >= {1'b0, divisor});
	assign diff  = trial - {1'b0, divisor};

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(LEVEL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			quo_q <= {quo_q[LEVEL_W-2:0], ge};
		end
	end

endmodule

// ===== hdl/bss_back.sv =====
// Back end: runs the sweep, latches the staircase and drives the result register.
module bss_back
	import bss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    head_valid,
	input  cmd_t    head_cmd,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	bk_state_t state_q, state_d;

	logic               running_q;
	logic               first_q;
	logic signed [15:0] step_q;
	logic signed [16:0] end_q;
	logic [COUNT_W-1:0] dwell_q;
	logic [COUNT_W-1:0] off_q;
	logic [COUNT_W-1:0] pulse_q;
	logic [COUNT_W-1:0] phase_q;
	logic signed [17:0] level_q;

	logic    out_valid_q;
	result_t out_q;

	// control from the sequencer
	logic    out_free;
	logic    div_start;
	logic    load;
	logic    tick_run;
	result_t res;
	logic    running_d;
	logic    first_d;

	// divider and latch path
	logic               div_done;
	logic [LEVEL_W-1:0] div_quo;
	logic               neg;
	logic [LEVEL_W-1:0] mag;
	logic [COUNT_W-1:0] n_eff;
	logic [COUNT_W-1:0] dwell_eff;
	logic signed [15:0] step_w;
	logic signed [16:0] end_w;
	logic signed [18:0] off_w;
	logic [COUNT_W-1:0] off_l;

	// tick path
	logic signed [17:0] end_x;
	logic               stop;
	logic [LEVEL_W-1:0] bias_w;
	logic [COUNT_W:0]   phase_inc;
	logic               wrap;
	logic               code_ok;
	logic [MASK_W-1:0]  arr_mask;

	assign neg       = (cfg.sweep_end < cfg.sweep_start);
	assign mag       = neg ? (cfg.sweep_start - cfg.sweep_end) : (cfg.sweep_end - cfg.sweep_start);
	assign n_eff     = (cfg.step_count == '0) ? COUNT_W'(1) : cfg.step_count;
	assign dwell_eff = (cfg.dwell_ticks == '0) ? COUNT_W'(1) : cfg.dwell_ticks;

	bss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (n_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		if (div_quo == '0) begin
			step_w = neg ? -16'sd1 : 16'sd1;
		end else begin
			step_w = neg ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});
		end
		end_w = signed'({2'b00, cfg.sweep_end}) + 17'(step_w);
		off_w = signed'({3'b000, dwell_eff}) - signed'({1'b0, cfg.pulse_ticks, 2'b00});
		off_l = off_w[18] ? COUNT_W'(1) : off_w[COUNT_W-1:0];
	end

	assign code_ok  = (cfg.array_code <= ARRAY_ALL);
	assign arr_mask = (cfg.array_code == ARRAY_ALL) ? MASK_W'(3'b111)
	                                                : MASK_W'(1) << cfg.array_code[1:0];

	// one step of the staircase from the running level
	always_comb begin
		end_x  = 18'(end_q);
		stop   = 1'b0;
		bias_w = level_q[LEVEL_W-1:0];
		if (!step_q[15]) begin
			if (level_q >= end_x) stop = 1'b1;
			if (level_q > signed'({3'b000, LEVEL_MAX})) begin
				bias_w = LEVEL_MAX;
				stop   = 1'b1;
			end
		end else begin
			if (level_q <= end_x) stop = 1'b1;
			if (level_q < signed'({3'b000, LEVEL_MIN})) begin
				bias_w = LEVEL_MIN;
				stop   = 1'b1;
			end
		end
		phase_inc = {1'b0, phase_q} + 1'b1;
		wrap      = (phase_inc == {1'b0, dwell_q});
	end

	assign out_free = !out_valid_q || out_ready;

	// sequencer: next state, pop, result
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		load      = 1'b0;
		tick_run  = 1'b0;
		running_d = running_q;
		first_d   = first_q;
		res       = '0;
		unique case (state_q)
			BK_EXEC: begin
				if (head_valid && out_free) begin
					if (head_cmd.op == OP_TICK && running_q && code_ok && first_q) begin
						// step size needed first; the tick stays at the head
						div_start = 1'b1;
						state_d   = BK_DIV;
					end else begin
						pop  = 1'b1;
						load = 1'b1;
						unique case (head_cmd.op)
							OP_MANUAL: begin
								res.write_valid  = (head_cmd.man_mask != '0);
								res.channel_mask = head_cmd.man_mask;
								res.bias_level   = (head_cmd.man_mask != '0) ? head_cmd.level : '0;
								running_d        = 1'b0;
							end
							OP_ARM: begin
								if (!running_q && code_ok) begin
									running_d = 1'b1;
									first_d   = 1'b1;
								end
							end
							default: begin
								if (running_q && !code_ok) begin
									running_d = 1'b0;
								end else if (running_q) begin
									tick_run         = 1'b1;
									running_d        = !stop;
									res.write_valid  = 1'b1;
									res.channel_mask = arr_mask;
									res.bias_level   = bias_w;
									if (phase_q == off_q && pulse_q != '0) begin
										res.cal_request = 1'b1;
										res.cal_length  = pulse_q;
									end
								end
							end
						endcase
						res.sweep_active = running_d;
					end
				end
			end
			BK_DIV: begin
				if (div_done) begin
					first_d = 1'b0;
					state_d = BK_EXEC;
				end
			end
			default: state_d = BK_EXEC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_EXEC;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			first_q     <= 1'b0;
			step_q      <= 16'sd1;
			end_q       <= '0;
			dwell_q     <= COUNT_W'(1);
			off_q       <= '0;
			pulse_q     <= '0;
			phase_q     <= '0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			running_q <= running_d;
			first_q   <= first_d;
			if (state_q == BK_DIV && div_done) begin
				step_q  <= step_w;
				end_q   <= end_w;
				dwell_q <= dwell_eff;
				off_q   <= off_l;
				pulse_q <= cfg.pulse_ticks;
				phase_q <= '0;
				level_q <= signed'({3'b000, cfg.sweep_start});
			end else if (tick_run) begin
				if (wrap) begin
					phase_q <= '0;
					level_q <= level_q + 18'(step_q);
				end else begin
					phase_q <= phase_inc[COUNT_W-1:0];
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hdl/bias_step_sweep.sv =====
// Top level of the staircase bias sweeper: register file, front end, queue, back end.
//
// Channel  Dir  Beat / access           Contents
// s_axis   in   tvalid & tready         tuser kind, tdata channel and level
// m_axis   out  tvalid & tready         tuser write_valid, tdata mask, level, flags, pulse
// apb      in   psel&penable&pwrite     six sweep registers at byte address 4*index
//
// Flow: a beat enters the queue in the cycle it is offered if the queue has room;
//   the back end pops a command and loads its result register in the same cycle.
// The first tick of each sweep is held at the queue head: the step size comes from a
//   15-step serial divider that the back end waits on before the tick runs.
// Reset clears the sequencer, queue and result valid flag and sets the registers to their defaults.
// A stalled m_axis holds the result register; the queue keeps taking beats until full.
module bias_step_sweep
	import bss_pkg::*;
#(
	parameter int QUEUE_DEPTH = BSS_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [23:0]  s_axis_tdata,   // [2:0] channel, [17:3] level, [23:18] zero
	input  logic [1:0]   s_axis_tuser,   // [1:0] kind
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [39:0]  m_axis_tdata,   // [4:0] channel_mask, [19:5] bias_level,
	                                     // [20] sweep_active, [21] cal_request,
	                                     // [37:22] cal_length, [39:38] zero
	output logic [0:0]   m_axis_tuser,   // [0] write_valid
	// register port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cfg_t             cfg_q;
	logic             cfg_wr;
	logic [2:0]       reg_idx;

	logic             push;
	cmd_t             push_cmd;
	logic             q_full;
	logic             pop;
	logic             head_valid;
	cmd_t             head_cmd;
	logic [CNT_W-1:0] q_count;
	result_t          res;

	// register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sweep_start <= '0;
			cfg_q.sweep_end   <= '0;
			cfg_q.step_count  <= COUNT_W'(1);
			cfg_q.dwell_ticks <= COUNT_W'(1);
			cfg_q.pulse_ticks <= '0;
			cfg_q.array_code  <= ARRAY_ALL;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SWEEP_START: cfg_q.sweep_start <= pwdata[LEVEL_W-1:0];
				REG_SWEEP_END:   cfg_q.sweep_end   <= pwdata[LEVEL_W-1:0];
				REG_STEP_COUNT:  cfg_q.step_count  <= pwdata[COUNT_W-1:0];
				REG_DWELL_TICKS: cfg_q.dwell_ticks <= pwdata[COUNT_W-1:0];
				REG_PULSE_TICKS: cfg_q.pulse_ticks <= pwdata[COUNT_W-1:0];
				REG_ARRAY_CODE:  cfg_q.array_code  <= pwdata[CODE_W-1:0];
				default: ;     // unmapped addresses are ignored
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_SWEEP_START: prdata = 32'(cfg_q.sweep_start);
			REG_SWEEP_END:   prdata = 32'(cfg_q.sweep_end);
			REG_STEP_COUNT:  prdata = 32'(cfg_q.step_count);
			REG_DWELL_TICKS: prdata = 32'(cfg_q.dwell_ticks);
			REG_PULSE_TICKS: prdata = 32'(cfg_q.pulse_ticks);
			REG_ARRAY_CODE:  prdata = 32'(cfg_q.array_code);
			default:         prdata = '0;
		endcase
	end

	// front end classifies beats into commands
	bss_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// decoupling queue
	bss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.count      (q_count)
	);

	// back end: sweep state, divider, result register
	bss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (res)
	);

	assign m_axis_tuser = res.write_valid;
	assign m_axis_tdata = {2'b00, res.cal_length, res.cal_request, res.sweep_active,
	                       res.bias_level, res.channel_mask};

	// a written level always names at least one channel, and no channel otherwise
	a_mask_vs_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[4:0] != 5'd0)))
		else $error("channel mask disagrees with write_valid");

	// no pulse length without a pulse request
	a_cal_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[21]) |-> (m_axis_tdata[37:22] == 16'd0))
		else $error("cal_length set without cal_request");

	// queue fill never exceeds its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CNT_W'(QUEUE_DEPTH))
		else $error("command queue overfilled");

	// an accepted beat with no pop grows the queue by one
	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !pop) |=> (q_count == $past(q_count) + 1'b1))
		else $error("accepted beat lost from queue");

endmodule
